// File: hw/rtl/postfix_stack_evaluator_macros.svh
// Assertion macros shared by the checker of the postfix evaluator.
// Depends on nothing; included by the checker file.
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH
// Assertion that holds whenever reset is released.
`define PSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that also holds in the cycle after reset.
`define PSE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/pse_pkg.sv
// Package of the postfix evaluator: command codes, widths and queue entry type.
// Depends on nothing; used by the top level, the front part and the back part.
`default_nettype none
package pse_pkg;
  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned QDepth = 2;

  typedef enum logic [3:0] {
    CMD_PUSH_NUM = 4'd0,
    CMD_PUSH_LET = 4'd1,
    CMD_NEG      = 4'd2,
    CMD_ADD      = 4'd3,
    CMD_SUB      = 4'd4,
    CMD_MUL      = 4'd5,
    CMD_DIV      = 4'd6,
    CMD_POW      = 4'd7
  } cmd_t;

  // Classified token as held in the queue between front and back.
  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] operand;
    logic        last;
  } tok_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_R,
    ST_POP_L,
    ST_RD_WAIT,
    ST_EXEC,
    ST_DIV,
    ST_POW,
    ST_PUSH,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/postfix_stack_evaluator.sv
// In the back part, divide runs on a serial divider that a zero divisor skips, and power
// runs on a serial unit that takes a multiply and a square per exponent bit.
// An accepted request is registered in the front queue, which holds two, before the back part takes it.
// The back part works on one token at a time; it pops the next one only from its idle state.
// After a token marked last the top of the stack is read, then the result is offered until taken.
// Reset (rst_n low, synchronous) empties the queue and stack and clears both flags.
`default_nettype none
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = pse_pkg::StackDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // command[3:0], number[34:4], letter[39:35]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // value[31:0]
  output logic [1:0]       out_tuser  // divide_by_zero[0], stack_error[1]
);
  logic q_valid, q_pop;
  pse_pkg::tok_t q_head;

  pse_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .command(in_tdata[3:0]), .number(in_tdata[34:4]), .letter(in_tdata[39:35]),
    .last(in_tlast), .q_valid, .q_pop, .q_head
  );

  pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_head,
    .out_valid(out_tvalid), .out_ready(out_tready), .value(out_tdata),
    .divide_by_zero(out_tuser[0]), .stack_error(out_tuser[1])
  );
endmodule
`default_nettype wire

// File: hw/rtl/pse_front.sv
// Front part: accepts tokens, forms the operand and queues the classified token.
// Depends on pse_pkg.
`default_nettype none
module pse_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [3:0]     command,
  input  wire logic [30:0]    number,
  input  wire logic [4:0]     letter,
  input  wire logic           last,
  output logic                q_valid,
  input  wire logic           q_pop,
  output pse_pkg::tok_t       q_head
);
  pse_pkg::tok_t q_mem_r [pse_pkg::QDepth];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  pse_pkg::tok_t tok;
  logic push;

  always_comb begin
    tok.cmd = command;
    tok.last = last;
    case (command)
      pse_pkg::CMD_PUSH_NUM: tok.operand = {1'b0, number};
      pse_pkg::CMD_PUSH_LET: tok.operand = {27'd0, letter};
      default:               tok.operand = 32'd0;
    endcase
  end

  assign in_ready = (q_cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_head = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wp_r] <= tok;
    end
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (q_pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/pse_divider.sv
// Iterative 32-bit signed divider, truncating, one quotient bit per cycle.
// Depends on nothing outside itself.
`default_nettype none
module pse_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] q_r, d_r;
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r, neg_r;
  logic [32:0] shifted, diff;

  assign shifted = {rem_r[31:0], q_r[31]};
  assign diff = shifted - {1'b0, d_r};
  assign done = busy_r && (cnt_r == 6'd0);
  assign quotient = neg_r ? (32'd0 - q_r) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd32;
      q_r <= dividend[31] ? (32'd0 - dividend) : dividend;
      d_r <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem_r <= 33'd0;
      neg_r <= dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
        if (!diff[32]) begin
          rem_r <= diff;
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r <= {q_r[30:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/pse_power.sv
// Saturating integer power by square and multiply, one exponent bit per multiply and square.
// Depends on nothing outside itself.
`default_nettype none
module pse_power (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] base,
  input  wire logic [31:0] expo,
  output logic             done,
  output logic [31:0]      result
);
  localparam logic [32:0] Cap = 33'h1_0000_0000 >> 1;
  logic [32:0] r_r, m_r;
  logic [31:0] e_r;
  logic        neg_r, busy_r, phase_r;
  logic [65:0] prod_r;
  logic [65:0] sq;
  logic [32:0] sat;
  logic [31:0] mag;

  assign mag = base[31] ? (32'd0 - base) : base;
  assign sq = {33'd0, m_r} * {33'd0, m_r};
  assign sat = (prod_r > {33'd0, Cap}) ? Cap : prod_r[32:0];
  assign done = busy_r && (e_r == 32'd0) && !phase_r;
  always_comb begin
    if (neg_r) result = (r_r >= Cap) ? 32'h8000_0000 : (32'd0 - r_r[31:0]);
    else       result = (r_r >= Cap) ? 32'h7FFF_FFFF : r_r[31:0];
  end

  // Phase 0 forms r*m when the exponent bit is set, phase 1 squares m.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      phase_r <= 1'b0;
      m_r <= {1'b0, mag};
      if (expo[31]) begin
        // A negative exponent leaves only bases 1 and -1 away from zero.
        r_r <= (base == 32'd1 || base == 32'hFFFF_FFFF) ? 33'd1 : 33'd0;
        e_r <= 32'd0;
        neg_r <= (base == 32'hFFFF_FFFF) & expo[0];
      end else begin
        r_r <= 33'd1;
        e_r <= expo;
        neg_r <= base[31] & expo[0];
      end
    end else if (busy_r) begin
      if (!phase_r) begin
        if (e_r == 32'd0) begin
          busy_r <= 1'b0;
        end else begin
          prod_r <= e_r[0] ? ({33'd0, r_r} * {33'd0, m_r}) : {33'd0, r_r};
          phase_r <= 1'b1;
        end
      end else begin
        r_r <= sat;
        e_r <= {1'b0, e_r[31:1]};
        m_r <= (sq > {33'd0, Cap}) ? Cap : sq[32:0];
        phase_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/pse_back.sv
// Back part: pops tokens from the queue, runs them on the operand stack, emits results.
// Depends on pse_pkg, pse_divider and pse_power.
`default_nettype none
module pse_back #(
  parameter int unsigned STACK_DEPTH = pse_pkg::StackDepthDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_pop,
  input  wire pse_pkg::tok_t q_head,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        value,
  output logic               divide_by_zero,
  output logic               stack_error
);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] Full = DW'(STACK_DEPTH);

  pse_pkg::state_t state_r, state_nxt;
  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_r, r_r, l_r, res_r;
  logic [DW-1:0] sp_r;
  logic dz_r, err_r;
  pse_pkg::tok_t tok_r;
  logic pop_second_r, l_ok_r, r_ok_r;
  logic div_start, div_done, pow_start, pow_done;
  logic [31:0] div_q, pow_q;
  logic is_bin;

  assign is_bin = (tok_r.cmd != pse_pkg::CMD_PUSH_NUM) && (tok_r.cmd != pse_pkg::CMD_PUSH_LET)
                  && (tok_r.cmd != pse_pkg::CMD_NEG);

  pse_divider u_div (.clk, .rst_n, .start(div_start), .dividend(l_r), .divisor(r_r),
                     .done(div_done), .quotient(div_q));
  pse_power u_pow (.clk, .rst_n, .start(pow_start), .base(l_r), .expo(r_r),
                   .done(pow_done), .result(pow_q));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pse_pkg::ST_IDLE:
        if (q_valid) begin
          if (q_head.cmd == pse_pkg::CMD_PUSH_NUM || q_head.cmd == pse_pkg::CMD_PUSH_LET)
            state_nxt = pse_pkg::ST_PUSH;
          else state_nxt = pse_pkg::ST_POP_R;
        end
      pse_pkg::ST_POP_R:   state_nxt = pse_pkg::ST_RD_WAIT;
      pse_pkg::ST_POP_L:   state_nxt = pse_pkg::ST_RD_WAIT;
      pse_pkg::ST_RD_WAIT: state_nxt = (is_bin && pop_second_r) ? pse_pkg::ST_POP_L
                                                               : pse_pkg::ST_EXEC;
      pse_pkg::ST_EXEC:
        case (tok_r.cmd)
          pse_pkg::CMD_DIV: state_nxt = (r_r == 32'd0) ? pse_pkg::ST_PUSH : pse_pkg::ST_DIV;
          pse_pkg::CMD_POW: state_nxt = pse_pkg::ST_POW;
          pse_pkg::CMD_NEG, pse_pkg::CMD_ADD, pse_pkg::CMD_SUB, pse_pkg::CMD_MUL:
            state_nxt = pse_pkg::ST_PUSH;
          default: state_nxt = tok_r.last ? pse_pkg::ST_FIN_RD : pse_pkg::ST_IDLE;
        endcase
      pse_pkg::ST_DIV:  if (div_done) state_nxt = pse_pkg::ST_PUSH;
      pse_pkg::ST_POW:  if (pow_done) state_nxt = pse_pkg::ST_PUSH;
      pse_pkg::ST_PUSH: state_nxt = tok_r.last ? pse_pkg::ST_FIN_RD : pse_pkg::ST_IDLE;
      pse_pkg::ST_FIN_RD: state_nxt = pse_pkg::ST_FIN_WAIT;
      pse_pkg::ST_FIN_WAIT: state_nxt = pse_pkg::ST_OUT;
      pse_pkg::ST_OUT: if (out_ready) state_nxt = pse_pkg::ST_IDLE;
      default: state_nxt = pse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == pse_pkg::ST_IDLE) && q_valid;
    div_start = (state_r == pse_pkg::ST_EXEC) && (tok_r.cmd == pse_pkg::CMD_DIV)
                && (r_r != 32'd0);
    pow_start = (state_r == pse_pkg::ST_EXEC) && (tok_r.cmd == pse_pkg::CMD_POW);
    out_valid = (state_r == pse_pkg::ST_OUT);
  end

  assign value = res_r;
  assign divide_by_zero = dz_r;
  assign stack_error = err_r;

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state_r == pse_pkg::ST_POP_R || state_r == pse_pkg::ST_POP_L ||
        state_r == pse_pkg::ST_FIN_RD) begin
      rd_r <= mem[AW'(sp_r - DW'(1))];
    end
    if (state_r == pse_pkg::ST_PUSH && sp_r < Full) begin
      mem[AW'(sp_r)] <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pse_pkg::ST_IDLE;
      sp_r <= '0;
      dz_r <= 1'b0;
      err_r <= 1'b0;
      pop_second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        pse_pkg::ST_IDLE:
          if (q_valid) begin
            tok_r <= q_head;
            res_r <= q_head.operand;
            pop_second_r <= 1'b1;
          end
        pse_pkg::ST_POP_R, pse_pkg::ST_POP_L: begin
          if (state_r == pse_pkg::ST_POP_R) r_ok_r <= (sp_r != '0);
          else l_ok_r <= (sp_r != '0);
          if (sp_r == '0) err_r <= 1'b1;
          else sp_r <= sp_r - DW'(1);
        end
        pse_pkg::ST_RD_WAIT:
          if (pop_second_r) begin
            r_r <= r_ok_r ? rd_r : 32'd0;
            pop_second_r <= 1'b0;
          end else begin
            l_r <= l_ok_r ? rd_r : 32'd0;
          end
        pse_pkg::ST_EXEC:
          case (tok_r.cmd)
            pse_pkg::CMD_NEG: res_r <= 32'd0 - r_r;
            pse_pkg::CMD_ADD: res_r <= l_r + r_r;
            pse_pkg::CMD_SUB: res_r <= l_r - r_r;
            pse_pkg::CMD_MUL: res_r <= 32'(l_r * r_r);
            pse_pkg::CMD_DIV:
              if (r_r == 32'd0) begin
                res_r <= 32'd0;
                dz_r <= 1'b1;
              end
            default: ;
          endcase
        pse_pkg::ST_DIV: if (div_done) res_r <= div_q;
        pse_pkg::ST_POW: if (pow_done) res_r <= pow_q;
        pse_pkg::ST_PUSH:
          if (sp_r < Full) sp_r <= sp_r + DW'(1);
          else err_r <= 1'b1;
        pse_pkg::ST_FIN_WAIT:
          if (sp_r == '0) begin
            res_r <= 32'd0;
            err_r <= 1'b1;
          end else begin
            res_r <= rd_r;
          end
        pse_pkg::ST_OUT:
          if (out_ready) begin
            sp_r <= '0;
            dz_r <= 1'b0;
            err_r <= 1'b0;
          end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/pse_checker.sv
// Port-level checker of the postfix evaluator, bound to the top level.
// Depends on postfix_stack_evaluator_macros.svh.
`default_nettype none
`include "postfix_stack_evaluator_macros.svh"
module pse_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  `PSE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `PSE_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable({out_tuser, out_tdata}), "result changed")
  `PSE_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid, "result right after reset")
  `PSE_ASSERT(a_no_back2back, out_tvalid && out_tready |=> !out_tvalid, "result repeated")
endmodule
bind postfix_stack_evaluator pse_checker u_chk (.*);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench of the postfix stack evaluator: directed table, overflow run,
// then random expressions and tokens, checked by a stack predictor. Depends on pse_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  localparam int unsigned DEPTH = pse_pkg::StackDepthDef;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ITEMS = 700;
  // Codes above the last operator pop two and push nothing.
  localparam logic [3:0] CMD_UNKNOWN = 4'd8;
  localparam logic [3:0] CMD_TOP = 4'd15;

  typedef struct {
    logic [3:0]  cmd;
    logic [30:0] number;
    logic [4:0]  letter;
    logic        last;
  } token_t;

  typedef struct {
    logic [31:0] value;
    logic        div_zero;
    logic        stack_err;
  } answer_t;

  typedef struct {
    token_t tok;
    logic   known;
    answer_t ans;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;

  postfix_stack_evaluator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Predictor state.
  logic [31:0] stk [DEPTH];
  int unsigned sp;
  logic dz_flag;
  logic err_flag;
  answer_t pending_answers[$];
  answer_t typed_answers[$];
  logic typed_valid[$];
  // Typed answer attached to the next last request, when the table gives one.
  logic row_known;
  answer_t row_ans;
  row_t table_rows[$];
  int errors;
  int unsigned cycles;
  int unsigned n_sent;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic is_neg(logic [31:0] x);
    return x[31];
  endfunction

  function automatic logic [31:0] mag(logic [31:0] x);
    return x[31] ? 32'd0 - x : x;
  endfunction

  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    q = mag(a) / mag(b);
    return (is_neg(a) != is_neg(b)) ? 32'd0 - q : q;
  endfunction

  function automatic logic [31:0] saturating_power(logic [31:0] base, logic [31:0] ex);
    logic [63:0] cap;
    logic [63:0] r;
    logic [63:0] m;
    logic neg;
    cap = 64'h8000_0000;
    r = 64'd1;
    if (is_neg(ex)) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    neg = is_neg(base) && ex[0];
    m = {32'd0, mag(base)};
    if (m > cap) m = cap;
    while (ex != 32'd0) begin
      if (ex[0]) begin
        r = r * m;
        if (r > cap) r = cap;
      end
      ex = ex >> 1;
      if (ex != 32'd0) begin
        m = m * m;
        if (m > cap) m = cap;
      end
    end
    if (neg) return (r >= cap) ? 32'h8000_0000 : 32'd0 - r[31:0];
    return (r >= cap) ? 32'h7FFF_FFFF : r[31:0];
  endfunction

  task automatic stack_push(logic [31:0] v);
    if (sp >= DEPTH) begin
      err_flag = 1'b1;
    end else begin
      stk[sp] = v;
      sp++;
    end
  endtask

  task automatic stack_pop(output logic [31:0] v);
    if (sp == 0) begin
      err_flag = 1'b1;
      v = 32'd0;
    end else begin
      sp--;
      v = stk[sp];
    end
  endtask

  // Applies one token to the predicted stack; queues an answer on the last token.
  task automatic evaluate_token(token_t t);
    logic [31:0] r;
    logic [31:0] l;
    answer_t a;
    case (t.cmd)
      pse_pkg::CMD_PUSH_NUM: stack_push({1'b0, t.number});
      pse_pkg::CMD_PUSH_LET: stack_push({27'd0, t.letter});
      pse_pkg::CMD_NEG: begin
        stack_pop(r);
        stack_push(32'd0 - r);
      end
      default: begin
        stack_pop(r);
        stack_pop(l);
        case (t.cmd)
          pse_pkg::CMD_ADD: stack_push(l + r);
          pse_pkg::CMD_SUB: stack_push(l - r);
          pse_pkg::CMD_MUL: stack_push(l * r);
          pse_pkg::CMD_DIV: begin
            if (r == 32'd0) begin
              dz_flag = 1'b1;
              stack_push(32'd0);
            end else begin
              stack_push(trunc_quotient(l, r));
            end
          end
          pse_pkg::CMD_POW: stack_push(saturating_power(l, r));
          default: ;
        endcase
      end
    endcase
    if (t.last) begin
      if (sp == 0) begin
        err_flag = 1'b1;
        a.value = 32'd0;
      end else begin
        a.value = stk[sp - 1];
      end
      a.div_zero = dz_flag;
      a.stack_err = err_flag;
      pending_answers.push_back(a);
      typed_valid.push_back(row_known);
      typed_answers.push_back(row_ans);
      sp = 0;
      dz_flag = 1'b0;
      err_flag = 1'b0;
    end
  endtask

  // Drives one request and waits for it to be taken; bursts with random gaps.
  task automatic send_token(token_t t);
    in_tdata <= {t.letter, t.number, t.cmd};
    in_tlast <= t.last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    evaluate_token(t);
    n_sent++;
    @(negedge clk);
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  // Receiver: stalls on a pattern that changes phase now and then.
  initial begin
    int unsigned mode;
    out_tready = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 9) == 0);
        default: out_tready <= (cycles % 7) < 3;
      endcase
    end
  end

  // Output checker.
  always @(posedge clk) begin
    answer_t e;
    logic has_typed;
    answer_t typed;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result value=%h flags=%b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        has_typed = typed_valid.pop_front();
        typed = typed_answers.pop_front();
        if (out_tdata !== e.value || out_tuser[0] !== e.div_zero
            || out_tuser[1] !== e.stack_err) begin
          $display("%0t mismatch: expected value=%h dz=%b err=%b, actual value=%h dz=%b err=%b",
                   $time, e.value, e.div_zero, e.stack_err, out_tdata, out_tuser[0],
                   out_tuser[1]);
          errors++;
        end
        if (has_typed && (out_tdata !== typed.value || out_tuser[0] !== typed.div_zero
            || out_tuser[1] !== typed.stack_err)) begin
          $display("%0t table mismatch: expected value=%h dz=%b err=%b, actual %h %b",
                   $time, typed.value, typed.div_zero, typed.stack_err, out_tdata, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic token_t mk(logic [3:0] c, logic [30:0] n, logic [4:0] l, logic lst);
    token_t t;
    t.cmd = c;
    t.number = n;
    t.letter = l;
    t.last = lst;
    return t;
  endfunction

  function automatic token_t rand_operand(logic lst);
    token_t t;
    int unsigned k;
    k = $urandom_range(0, 9);
    t = mk(pse_pkg::CMD_PUSH_NUM, 31'($urandom()), 5'($urandom()), lst);
    if (k < 3) t.cmd = pse_pkg::CMD_PUSH_LET;
    else if (k < 6) t.number = 31'($urandom_range(0, 12));
    else if (k == 6) t.number = ($urandom_range(0, 1) == 1) ? 31'h7FFF_FFFF : 31'd0;
    return t;
  endfunction

  function automatic logic [3:0] rand_operator();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k < 17) return pse_pkg::CMD_NEG + 4'(k % 6);
    if (k < 19) return CMD_UNKNOWN + 4'($urandom_range(0, 7));
    return pse_pkg::CMD_NEG;
  endfunction

  // Random expression: operands and operators keeping depth sane, one result at the end.
  task automatic send_expression();
    int unsigned len;
    int unsigned depth;
    logic [3:0] op;
    len = $urandom_range(1, 12);
    depth = 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (depth < 2 || $urandom_range(0, 1) == 0) begin
        send_token(rand_operand(1'b0));
        depth++;
      end else begin
        op = rand_operator();
        send_token(mk(op, 31'($urandom()), 5'($urandom()), 1'b0));
        if (op != pse_pkg::CMD_NEG) depth -= (op > pse_pkg::CMD_POW) ? 2 : 1;
      end
    end
    if (depth > 1) begin
      while (depth > 1) begin
        send_token(mk(pse_pkg::CMD_NEG + 4'($urandom_range(1, 5)), 31'($urandom()),
                      5'($urandom()), depth == 2));
        depth--;
      end
    end else if (depth == 1) begin
      send_token(mk(pse_pkg::CMD_NEG, 31'd0, 5'd0, 1'b1));
    end else begin
      send_token(rand_operand(1'b1));
    end
  endtask

  task automatic wait_drain();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(token_t t, logic known, logic [31:0] v, logic dz, logic er);
    row_t r;
    r.tok = t;
    r.known = known;
    r.ans.value = v;
    r.ans.div_zero = dz;
    r.ans.stack_err = er;
    table_rows.push_back(r);
  endtask

  initial begin
    sp = 0;
    dz_flag = 1'b0;
    err_flag = 1'b0;
    errors = 0;
    cycles = 0;
    n_sent = 0;
    row_known = 1'b0;
    row_ans.value = 32'd0;
    row_ans.div_zero = 1'b0;
    row_ans.stack_err = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;

    // Empty at end, extremes, letters, negate overflow, divide by zero and overflow,
    // power corner cases, unknown operator and underflow.
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd0, 5'd0, 1'b1), 1'b1, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'h7FFF_FFFF, 5'h1F, 1'b1), 1'b1, 32'h7FFF_FFFF,
            1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_LET, 31'h7FFF_FFFF, 5'd31, 1'b1), 1'b1, 32'd31, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_NEG, 31'd0, 5'd0, 1'b1), 1'b1, 32'd0, 1'b0, 1'b1);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd7, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_DIV, 31'd0, 5'd0, 1'b1), 1'b1, 32'd0, 1'b1, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'h7FFF_FFFF, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_LET, 31'd0, 5'd1, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_ADD, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_NEG, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_LET, 31'd0, 5'd1, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_NEG, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_DIV, 31'd0, 5'd0, 1'b1), 1'b1, 32'h8000_0000, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_POW, 31'd0, 5'd0, 1'b1), 1'b1, 32'd1, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd3, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd40, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_POW, 31'd0, 5'd0, 1'b1), 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0);
    // Negative exponents: a plain base gives 0, bases 1 and -1 keep their magnitude.
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd2, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd1, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_NEG, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_POW, 31'd0, 5'd0, 1'b1), 1'b1, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd1, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_NEG, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd3, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_NEG, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_POW, 31'd0, 5'd0, 1'b1), 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd1, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd1, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_NEG, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_POW, 31'd0, 5'd0, 1'b1), 1'b1, 32'd1, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_PUSH_NUM, 31'd5, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(CMD_UNKNOWN, 31'd0, 5'd0, 1'b1), 1'b1, 32'd0, 1'b0, 1'b1);
    add_row(mk(pse_pkg::CMD_PUSH_LET, 31'd0, 5'd2, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(pse_pkg::CMD_SUB, 31'd0, 5'd0, 1'b0), 1'b0, 32'd0, 1'b0, 1'b0);
    add_row(mk(CMD_TOP, 31'd0, 5'd0, 1'b1), 1'b1, 32'd0, 1'b0, 1'b1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (table_rows[i]) begin
      row_known = table_rows[i].known;
      row_ans = table_rows[i].ans;
      send_token(table_rows[i].tok);
    end
    row_known = 1'b0;
    in_tvalid <= 1'b0;
    wait_drain();

    // Overflow: push one more than the stack holds; the dropped push flags an error.
    for (int unsigned i = 0; i <= DEPTH; i++) begin
      if (i == DEPTH) begin
        row_known = 1'b1;
        row_ans.value = 32'(DEPTH - 1);
        row_ans.div_zero = 1'b0;
        row_ans.stack_err = 1'b1;
      end
      send_token(mk(pse_pkg::CMD_PUSH_NUM, 31'(i), 5'd0, i == DEPTH));
    end
    row_known = 1'b0;

    while (n_sent < ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_token(mk(4'($urandom()), 31'($urandom()), 5'($urandom()),
                      $urandom_range(0, 3) == 0));
      end else begin
        send_expression();
      end
      if ($urandom_range(0, 60) == 0) begin
        in_tvalid <= 1'b0;
        wait_drain();
      end
    end
    in_tvalid <= 1'b0;
    wait_drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
